>>> rtl/tmbe_pkg.sv
`timescale 1ns / 1ps
package tmbe_pkg;

  localparam int TAPE_DEPTH    = 32768;
  localparam int PROGRAM_DEPTH = 4096;
  localparam int NEST_DEPTH    = 64;

  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int PROG_AW = $clog2(PROGRAM_DEPTH);
  localparam int NEST_AW = $clog2(NEST_DEPTH);
  localparam int LEN_W   = PROG_AW + 1;
  localparam int LVL_W   = NEST_AW + 1;
  localparam int ARG_W   = (TAPE_AW > PROG_AW) ? TAPE_AW : PROG_AW;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_STEP   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_RIGHT = 4'd0,
    OP_LEFT  = 4'd1,
    OP_INC   = 4'd2,
    OP_DEC   = 4'd3,
    OP_OUT   = 4'd4,
    OP_IN    = 4'd5,
    OP_OPEN  = 4'd6,
    OP_CLOSE = 4'd7,
    OP_NONE  = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    PH_LOADING = 2'd0,
    PH_READY   = 2'd1,
    PH_HALTED  = 2'd2,
    PH_ERROR   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_IDLE            = 3'd1,
    ST_UNMATCHED_CLOSE = 3'd2,
    ST_UNMATCHED_OPEN  = 3'd3,
    ST_FULL            = 3'd4,
    ST_DEEP            = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [ARG_W-1:0] arg;
  } instr_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic patch;
    logic clr_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_patch;
    logic go_clear;
    logic clr_done;
  } dp_stat_t;

  function automatic op_e decode_char(input logic [7:0] c);
    op_e o;
    unique case (c)
      8'h3E:   o = OP_RIGHT;
      8'h3C:   o = OP_LEFT;
      8'h2B:   o = OP_INC;
      8'h2D:   o = OP_DEC;
      8'h2E:   o = OP_OUT;
      8'h2C:   o = OP_IN;
      8'h5B:   o = OP_OPEN;
      8'h5D:   o = OP_CLOSE;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

endpackage

>>> rtl/tmbe_ctrl.sv
`timescale 1ns / 1ps
module tmbe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmbe_pkg::dp_stat_t  stat_i,
  output tmbe_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_EX,
    S_PATCH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_EX;
      end
      S_EX: begin
        // hold until the output slot is free; item runs exactly once
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          if (stat_i.need_patch)    state_d = S_PATCH;
          else if (stat_i.go_clear) state_d = S_CLR;
          else                      state_d = S_IDLE;
        end
      end
      S_PATCH: begin
        cmd_o.patch = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/tmbe_dp.sv
`timescale 1ns / 1ps
module tmbe_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmbe_pkg::ctrl_cmd_t cmd_i,
  output tmbe_pkg::dp_stat_t  stat_o,
  input  logic [1:0]          in_cmd_i,
  input  logic [7:0]          in_char_i,
  input  logic [7:0]          in_byte_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                res_valid_o,
  output logic [7:0]          res_byte_o,
  output logic [2:0]          res_status_o
);

  localparam int TAW = tmbe_pkg::TAPE_AW;
  localparam int PAW = tmbe_pkg::PROG_AW;
  localparam int NAW = tmbe_pkg::NEST_AW;
  localparam int LW  = tmbe_pkg::LEN_W;
  localparam int VW  = tmbe_pkg::LVL_W;
  localparam int AW  = tmbe_pkg::ARG_W;

  // memories
  tmbe_pkg::instr_t prog_mem [tmbe_pkg::PROGRAM_DEPTH];
  logic [7:0]       tape_mem [tmbe_pkg::TAPE_DEPTH];
  logic [PAW-1:0]   stk_mem  [tmbe_pkg::NEST_DEPTH];

  tmbe_pkg::instr_t prog_rd_q;
  logic [7:0]       tape_rd_q;
  logic [PAW-1:0]   stk_rd_q;

  tmbe_pkg::cmd_e   cmd_q;
  logic [7:0]       ch_q, ib_q;

  logic [LW-1:0]    len_q, len_d;
  logic [VW-1:0]    lvl_q, lvl_d;
  tmbe_pkg::op_e    prev_q, prev_d;
  logic [LW-1:0]    pc_q, pc_d;
  logic [TAW-1:0]   ptr_q, ptr_d;
  tmbe_pkg::phase_e phase_q, phase_d;
  tmbe_pkg::status_e err_q, err_d;
  logic [AW-1:0]    last_q, last_d;
  logic [PAW-1:0]   pat_addr_q, pat_addr_d;
  logic [PAW-1:0]   pat_here_q, pat_here_d;
  logic [TAW-1:0]   clr_q;

  logic             out_valid_q, res_valid_q;
  logic [7:0]       res_byte_q;
  tmbe_pkg::status_e res_status_q;

  // exec results
  logic              x_prog_we, x_tape_we, x_stk_we, x_valid, x_patch, x_clear;
  logic [PAW-1:0]    x_prog_addr;
  tmbe_pkg::instr_t  x_prog_data;
  logic [7:0]        x_tape_data, x_byte;
  tmbe_pkg::status_e x_status;

  tmbe_pkg::op_e     op;
  logic [AW-1:0]     new_arg;
  logic [TAW:0]      sum;
  logic [TAW-1:0]    marg;
  logic              jump;

  assign op   = tmbe_pkg::decode_char(ch_q);
  assign marg = prog_rd_q.arg[TAW-1:0];

  always_comb begin
    len_d = len_q; lvl_d = lvl_q; prev_d = prev_q; pc_d = pc_q; ptr_d = ptr_q;
    phase_d = phase_q; err_d = err_q; last_d = last_q;
    pat_addr_d = pat_addr_q; pat_here_d = pat_here_q;
    x_prog_we = 1'b0; x_tape_we = 1'b0; x_stk_we = 1'b0;
    x_valid = 1'b0; x_byte = '0; x_patch = 1'b0; x_clear = 1'b0;
    x_prog_addr = len_q[PAW-1:0];
    x_prog_data = '0;
    x_tape_data = '0;
    x_status = tmbe_pkg::ST_OK;
    new_arg = '0;
    sum = '0;
    jump = 1'b0;
    if (cmd_q == tmbe_pkg::CMD_CLEAR) begin
      len_d = '0; lvl_d = '0; prev_d = tmbe_pkg::OP_NONE; pc_d = '0; ptr_d = '0;
      phase_d = tmbe_pkg::PH_LOADING; err_d = tmbe_pkg::ST_OK;
    end else if (phase_q == tmbe_pkg::PH_ERROR) begin
      x_status = err_q;
    end else begin
      unique case (cmd_q)
        tmbe_pkg::CMD_LOAD: begin
          if (phase_q != tmbe_pkg::PH_LOADING) begin
            x_status = tmbe_pkg::ST_IDLE;
          end else begin
            prev_d = op;
            if (op == tmbe_pkg::OP_NONE) begin
              x_status = tmbe_pkg::ST_OK;
            end else if (op <= tmbe_pkg::OP_DEC && prev_q == op && len_q != '0) begin
              // merge into the last instruction
              if (op <= tmbe_pkg::OP_LEFT) begin
                if (last_q[TAW-1:0] == TAW'(tmbe_pkg::TAPE_DEPTH - 1)) new_arg = '0;
                else new_arg = AW'(last_q[TAW-1:0] + TAW'(1));
              end else begin
                new_arg = AW'(last_q[7:0] + 8'd1);
              end
              last_d      = new_arg;
              x_prog_we   = 1'b1;
              x_prog_addr = PAW'(len_q - LW'(1));
              x_prog_data = '{op: op[2:0], arg: new_arg};
            end else if (op == tmbe_pkg::OP_CLOSE && lvl_q == '0) begin
              x_status = tmbe_pkg::ST_UNMATCHED_CLOSE;
              err_d = x_status; phase_d = tmbe_pkg::PH_ERROR;
            end else if (len_q >= LW'(tmbe_pkg::PROGRAM_DEPTH)) begin
              x_status = tmbe_pkg::ST_FULL;
              err_d = x_status; phase_d = tmbe_pkg::PH_ERROR;
            end else if (op == tmbe_pkg::OP_OPEN && lvl_q >= VW'(tmbe_pkg::NEST_DEPTH)) begin
              x_status = tmbe_pkg::ST_DEEP;
              err_d = x_status; phase_d = tmbe_pkg::PH_ERROR;
            end else begin
              if (op <= tmbe_pkg::OP_DEC) begin
                new_arg = AW'(1);
              end else if (op == tmbe_pkg::OP_OPEN) begin
                x_stk_we = 1'b1;
                lvl_d    = lvl_q + VW'(1);
              end else if (op == tmbe_pkg::OP_CLOSE) begin
                lvl_d      = lvl_q - VW'(1);
                new_arg    = AW'(stk_rd_q);
                pat_addr_d = stk_rd_q;
                pat_here_d = len_q[PAW-1:0];
                x_patch    = 1'b1;
              end
              last_d      = new_arg;
              x_prog_we   = 1'b1;
              x_prog_data = '{op: op[2:0], arg: new_arg};
              len_d       = len_q + LW'(1);
            end
          end
        end
        tmbe_pkg::CMD_FINISH: begin
          if (lvl_q != '0) begin
            x_status = tmbe_pkg::ST_UNMATCHED_OPEN;
            err_d = x_status; phase_d = tmbe_pkg::PH_ERROR;
          end else begin
            pc_d = '0; ptr_d = '0; phase_d = tmbe_pkg::PH_READY; x_clear = 1'b1;
          end
        end
        tmbe_pkg::CMD_STEP: begin
          if (phase_q != tmbe_pkg::PH_READY) begin
            x_status = tmbe_pkg::ST_IDLE;
          end else if (pc_q >= len_q) begin
            phase_d  = tmbe_pkg::PH_HALTED;
            x_status = tmbe_pkg::ST_IDLE;
          end else begin
            unique case (prog_rd_q.op)
              3'(tmbe_pkg::OP_RIGHT): begin
                sum = {1'b0, ptr_q} + {1'b0, marg};
                if (sum >= (TAW+1)'(tmbe_pkg::TAPE_DEPTH))
                  sum = sum - (TAW+1)'(tmbe_pkg::TAPE_DEPTH);
                ptr_d = sum[TAW-1:0];
              end
              3'(tmbe_pkg::OP_LEFT): begin
                if (ptr_q >= marg) sum = {1'b0, ptr_q} - {1'b0, marg};
                else sum = {1'b0, ptr_q} + (TAW+1)'(tmbe_pkg::TAPE_DEPTH) - {1'b0, marg};
                ptr_d = sum[TAW-1:0];
              end
              3'(tmbe_pkg::OP_INC): begin
                x_tape_we = 1'b1; x_tape_data = tape_rd_q + prog_rd_q.arg[7:0];
              end
              3'(tmbe_pkg::OP_DEC): begin
                x_tape_we = 1'b1; x_tape_data = tape_rd_q - prog_rd_q.arg[7:0];
              end
              3'(tmbe_pkg::OP_OUT): begin
                x_valid = 1'b1; x_byte = tape_rd_q;
              end
              3'(tmbe_pkg::OP_IN): begin
                x_tape_we = 1'b1; x_tape_data = ib_q;
              end
              3'(tmbe_pkg::OP_OPEN):  jump = (tape_rd_q == 8'd0);
              default:                jump = (tape_rd_q != 8'd0);
            endcase
            pc_d = (jump ? LW'(prog_rd_q.arg[PAW-1:0]) : pc_q) + LW'(1);
          end
        end
        default: x_status = tmbe_pkg::ST_OK;
      endcase
    end
  end

  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.need_patch = x_patch;
  assign stat_o.go_clear   = x_clear;
  assign stat_o.clr_done   = (clr_q == TAW'(tmbe_pkg::TAPE_DEPTH - 1));

  // program store: one write port shared by exec and the patch pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.patch) begin
      prog_mem[pat_addr_q] <= '{op: 3'(tmbe_pkg::OP_OPEN), arg: AW'(pat_here_q)};
    end else if (cmd_i.exec && x_prog_we) begin
      prog_mem[x_prog_addr] <= x_prog_data;
    end
    if (cmd_i.accept) prog_rd_q <= prog_mem[pc_q[PAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      tape_mem[clr_q] <= 8'd0;
    end else if (cmd_i.exec && x_tape_we) begin
      tape_mem[ptr_q] <= x_tape_data;
    end
    if (cmd_i.accept) tape_rd_q <= tape_mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && x_stk_we) stk_mem[lvl_q[NAW-1:0]] <= len_q[PAW-1:0];
    if (cmd_i.accept) stk_rd_q <= stk_mem[NAW'(lvl_q - VW'(1))];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= tmbe_pkg::cmd_e'(in_cmd_i);
      ch_q  <= in_char_i;
      ib_q  <= in_byte_i;
    end
    if (cmd_i.exec) begin
      res_valid_q  <= x_valid;
      res_byte_q   <= x_byte;
      res_status_q <= x_status;
      last_q       <= last_d;
      pat_addr_q   <= pat_addr_d;
      pat_here_q   <= pat_here_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      lvl_q       <= '0;
      prev_q      <= tmbe_pkg::OP_NONE;
      pc_q        <= '0;
      ptr_q       <= '0;
      phase_q     <= tmbe_pkg::PH_LOADING;
      err_q       <= tmbe_pkg::ST_OK;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        len_q   <= len_d;
        lvl_q   <= lvl_d;
        prev_q  <= prev_d;
        pc_q    <= pc_d;
        ptr_q   <= ptr_d;
        phase_q <= phase_d;
        err_q   <= err_d;
      end
      if (cmd_i.clr_en) begin
        clr_q <= stat_o.clr_done ? '0 : clr_q + TAW'(1);
      end
      if (cmd_i.exec)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign res_valid_o  = res_valid_q;
  assign res_byte_o   = res_byte_q;
  assign res_status_o = res_status_q;

endmodule

>>> rtl/tape_machine_bytecode_engine.sv
`timescale 1ns / 1ps
// Eight-symbol tape machine. Each item carries a command in tuser: clear,
// load one source character, finish loading, or execute one step. Every item
// yields exactly one result item (flag, byte, status). Each item is first
// latched while the program store, tape and bracket stack are read, then
// executed and written back once the output slot is free. A matched ']'
// during loading adds a patch step for the matching '[' through the single
// program store write port. After reset and each successful finish, the tape
// is zeroed over all TAPE_DEPTH cells (32768); no item is taken meanwhile. A
// result waits in the output register while the next item is accepted.
module tape_machine_bytecode_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] source_char, [15:8] input_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, zero fill
  output logic        m_axis_tuser    // [0] out_valid
);

  tmbe_pkg::ctrl_cmd_t cmd;
  tmbe_pkg::dp_stat_t  stat;
  logic [7:0]          res_byte;
  logic [2:0]          res_status;

  tmbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tmbe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_cmd_i     (s_axis_tuser),
    .in_char_i    (s_axis_tdata[7:0]),
    .in_byte_i    (s_axis_tdata[15:8]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .res_valid_o  (m_axis_tuser),
    .res_byte_o   (res_byte),
    .res_status_o (res_status)
  );

  assign m_axis_tdata = {5'd0, res_status, res_byte};

endmodule
